[rtl/skcp_pkg.sv]
// skcp_pkg: shared types, byte codes and keyword tables for the keyword command parser
// no dependencies; imported by skcp_match and serial_keyword_command_parser
package skcp_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // byte codes
  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SP      = 8'd32;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_Z = "z";
  localparam logic [7:0] CASE_DIFF  = "a" - "A";

  // keyword table
  localparam int KW_COUNT   = 13;
  localparam int KW_MAX_LEN = 9;
  // position counter saturates one above the longest keyword
  localparam int KW_POS_W   = $clog2(KW_MAX_LEN + 2);
  localparam logic [KW_POS_W-1:0] KW_POS_SAT = KW_POS_W'(KW_MAX_LEN + 1);

  localparam logic [7:0] KW_CHARS [KW_COUNT][KW_MAX_LEN] = '{
    '{"A", "U", "T", "O", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "D", "L", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"C", "U", "R", "I", "O", "U", "S", 8'h00, 8'h00},
    '{"T", "H", "I", "N", "K", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"T", "H", "I", "N", "K", "I", "N", "G", 8'h00},
    '{"L", "I", "S", "T", "E", "N", 8'h00, 8'h00, 8'h00},
    '{"L", "I", "S", "T", "E", "N", "I", "N", "G"},
    '{"H", "A", "P", "P", "Y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "L", "E", "E", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "L", "E", "E", "P", "Y", 8'h00, 8'h00, 8'h00},
    '{"S", "P", "E", "A", "K", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "P", "E", "A", "K", "I", "N", "G", 8'h00},
    '{"A", "L", "E", "R", "T", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [KW_POS_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd4, 4'd7, 4'd5, 4'd8, 4'd6, 4'd9, 4'd5, 4'd5, 4'd6, 4'd5, 4'd8, 4'd5
  };

  localparam logic [3:0] KW_CODE [KW_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8
  };

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // sequencer to matcher
  typedef struct packed {
    logic       clear;
    logic       step;
    logic [7:0] chr;
  } match_ctl_t;

  // matcher to sequencer
  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } match_res_t;

endpackage

[rtl/skcp_ram.sv]
// skcp_ram: generic single write, single read RAM with registered read data
// no dependencies
module skcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/skcp_match.sv]
// skcp_match: keyword matcher, one normalised character per step against all keywords
// depends on skcp_pkg
module skcp_match
  import skcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  match_ctl_t ctl,
  output match_res_t res
);

  logic [KW_COUNT-1:0] alive_r, alive_nxt;
  logic [KW_POS_W-1:0] pos_r, pos_nxt;

  always_comb begin
    alive_nxt = alive_r;
    pos_nxt   = pos_r;
    if (ctl.clear) begin
      alive_nxt = '1;
      pos_nxt   = '0;
    end else if (ctl.step) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        alive_nxt[k] = alive_r[k] && (pos_r < KW_LEN[k]) &&
                       (KW_CHARS[k][pos_r] == ctl.chr);
      end
      pos_nxt = (pos_r == KW_POS_SAT) ? pos_r : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= '1;
      pos_r   <= '0;
    end else begin
      alive_r <= alive_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // full match: prefix still alive and length used up
  always_comb begin
    res.hit  = 1'b0;
    res.code = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (alive_r[k] && (KW_LEN[k] == pos_r)) begin
        res.hit  = 1'b1;
        res.code = KW_CODE[k];
      end
    end
  end

endmodule

[rtl/serial_keyword_command_parser.sv]
// serial_keyword_command_parser: line buffer, scan sequencer and result register
// depends on skcp_pkg, skcp_ram, skcp_match
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_rx_byte[7:0]      | request in
//  out     | out_valid, out_stall, out_status[1:0],   | request out
//          | out_command_code[3:0]                   |
//
// ordinary bytes and backspaces are handled in the idle state without a scan
// a line end starts a scan: one ram read per stored byte through the
//   single read port, each fed to the shared keyword compare unit, then the
//   FIN state registers the verdict; fewer reads if a zero byte ends the text early
// while a line is scanned in_stall is high
// a request that would give a result waits while the output register is full
// synchronous active-low reset clears length, sequencer and output valid;
//   the line store itself is not cleared
module serial_keyword_command_parser
  import skcp_pkg::*;
#(
  parameter int LINE_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [3:0] out_command_code
);

  localparam int DEPTH = LINE_BYTES - 1;
  localparam int LW    = $clog2(LINE_BYTES);
  localparam int AW    = $clog2(DEPTH);

  state_t         state_r, state_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [3:0]     out_code_r, out_code_nxt;

  // input byte classes
  logic is_eol, is_bs, full, needs_out, accept;

  // scan side
  logic [7:0]    scan_byte, scan_chr;
  logic          scan_nul, scan_space, scan_last;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  match_ctl_t    mctl;
  match_res_t    mres;

  assign is_eol = (in_rx_byte == CH_CR) || (in_rx_byte == CH_LF);
  assign is_bs  = (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL);
  assign full   = (len_r == LW'(DEPTH));

  // requests that produce a result need the output register free
  assign needs_out = (is_eol && (len_r != '0)) || (!is_eol && !is_bs && full);
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && needs_out);
  assign accept    = in_valid && !in_stall;

  assign ram_we = accept && !is_eol && !is_bs && !full;

  skcp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (in_rx_byte),
    .raddr (ram_raddr),
    .rdata (scan_byte)
  );

  // normalise the byte read out of the store
  assign scan_nul   = (scan_byte == CH_NUL);
  assign scan_space = (scan_byte == CH_SP) || (scan_byte == CH_TAB) ||
                      (scan_byte == CH_CR) || (scan_byte == CH_LF);
  assign scan_chr   = ((scan_byte >= CH_LOWER_A) && (scan_byte <= CH_LOWER_Z)) ?
                      (scan_byte - CASE_DIFF) : scan_byte;
  assign scan_last  = ((LW'(idx_r) + 1'b1) == len_r);

  // read address runs one entry ahead during the scan; address 0 is
  // presented while idle so the first byte is ready when the scan starts
  always_comb begin
    if (state_r == ST_SCAN && !scan_last) begin
      ram_raddr = idx_r + 1'b1;
    end else if (state_r == ST_SCAN) begin
      ram_raddr = idx_r;
    end else begin
      ram_raddr = '0;
    end
  end

  assign mctl.clear = accept && is_eol;
  assign mctl.step  = (state_r == ST_SCAN) && !scan_nul && !scan_space;
  assign mctl.chr   = scan_chr;

  skcp_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .res   (mres)
  );

  // sequencer next state and outputs
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_code_nxt   = out_code_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_eol) begin
            // empty line end is ignored
            if (len_r != '0) begin
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          end else if (is_bs) begin
            if (len_r != '0) begin
              len_nxt = len_r - 1'b1;
            end
          end else if (full) begin
            // overflow: drop the byte, clear the line, report too long
            len_nxt        = '0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_TOO_LONG;
            out_code_nxt   = '0;
          end else begin
            len_nxt = len_r + 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (scan_nul || scan_last) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FIN: begin
        len_nxt        = '0;
        out_valid_nxt  = 1'b1;
        out_status_nxt = mres.hit ? STATUS_OK : STATUS_UNKNOWN;
        out_code_nxt   = mres.hit ? mres.code : 4'd0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_code_r   <= out_code_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_command_code = out_code_r;

  // line length never passes the store depth
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(DEPTH))
    else $error("line length beyond store depth");

  // scan index stays inside the stored line
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (LW'(idx_r) < len_r))
    else $error("scan index outside line");

  // a finished scan always leaves an empty line and a pending result
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (len_r == '0) && out_valid_r)
    else $error("line end did not clear line or post result");

  // command code is zero unless a keyword was recognised
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STATUS_OK)) |-> (out_code_r == 4'd0))
    else $error("command code set on failed line");

  // a scan only starts with the output register free
  a_scan_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && (state_nxt == ST_SCAN)) |-> !out_valid_r)
    else $error("scan started with result pending");

endmodule

[tb/sv/tb_serial_keyword_command_parser.sv]
// tb_serial_keyword_command_parser: self-checking regression for the keyword command parser
// depends on skcp_pkg and serial_keyword_command_parser; a line predictor in here gives the
// expected verdict for every request, and a checker compares each delivered verdict with it
`timescale 1ns / 1ps

module tb_serial_keyword_command_parser
  import skcp_pkg::*;
;

  localparam int LINE_BYTES     = 32;
  localparam int STORE_DEPTH    = LINE_BYTES - 1;
  localparam int KW_N           = 13;
  localparam int ITEM_TARGET    = 1350;
  // a line end scans at most the stored line, so leave time after it for settling
  localparam int TAIL_CYCLES    = 4 * (LINE_BYTES + 2);
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTED   = 10;
  localparam int PATTERN_LEN    = 13;

  // command codes as carried on out_command_code
  typedef enum logic [3:0] {
    CMD_AUTO, CMD_IDLE, CMD_CURIOUS, CMD_THINK, CMD_LISTEN,
    CMD_HAPPY, CMD_SLEEP, CMD_SPEAK, CMD_ALERT
  } command_t;

  // code field value whenever nothing was recognised
  localparam logic [3:0] CODE_BLANK = 4'd0;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] code;
  } verdict_t;

  // what one accepted byte does to the line
  typedef enum {LINE_IGNORED, LINE_UPDATED, LINE_VERDICT} line_effect_t;

  // receiver behaviour
  typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_style_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [3:0] out_command_code;

  // keyword table with aliases, kept independently of the design
  string    kw_text [KW_N] = '{"AUTO", "IDLE", "CURIOUS", "THINK", "THINKING", "LISTEN",
                               "LISTENING", "HAPPY", "SLEEP", "SLEEPY", "SPEAK",
                               "SPEAKING", "ALERT"};
  command_t kw_cmd  [KW_N] = '{CMD_AUTO, CMD_IDLE, CMD_CURIOUS, CMD_THINK, CMD_THINK,
                               CMD_LISTEN, CMD_LISTEN, CMD_HAPPY, CMD_SLEEP, CMD_SLEEP,
                               CMD_SPEAK, CMD_SPEAK, CMD_ALERT};

  // predictor copy of the raw line
  logic [7:0] line_bytes [STORE_DEPTH];
  int         line_len = 0;

  verdict_t   pending_verdicts [$];
  verdict_t   oldest_verdict;
  int         mismatch_count = 0;
  int         items_counted = 0;
  int         quiet_cycles = 0;

  // sender burst control, only touched by the stimulus thread
  bit         tx_gaps_on = 1'b0;
  int         burst_left = 0;

  // receiver control: the stimulus thread asks, the stall process serves
  rx_style_t  rx_style = RX_FREE;
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  logic [PATTERN_LEN-1:0] stall_pattern = 13'b0010110010100;
  int         pattern_pos = 0;
  logic       stall_next;

  serial_keyword_command_parser #(
    .LINE_BYTES(LINE_BYTES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_command_code (out_command_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // line predictor
  // ---------------------------------------------------------------------------

  // normalise the stored line and look it up in the keyword table
  function automatic verdict_t judge_line();
    logic [7:0] text [$];
    logic [7:0] c;
    verdict_t   v;
    bit         same;
    v.status = STATUS_UNKNOWN;
    v.code   = CODE_BLANK;
    for (int i = 0; i < line_len; i++) begin
      c = line_bytes[i];
      // a zero byte cuts the text short
      if (c == CH_NUL) break;
      // blanks and stray line-end bytes are dropped
      if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF) continue;
      // only a-z fold; bytes above 127 pass untouched
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_DIFF;
      text.push_back(c);
    end
    // empty text never matches as no keyword has length zero
    for (int k = 0; k < KW_N; k++) begin
      if (kw_text[k].len() == text.size()) begin
        same = 1'b1;
        foreach (text[j]) if (text[j] != kw_text[k][j]) same = 1'b0;
        if (same) begin
          v.status = STATUS_OK;
          v.code   = kw_cmd[k];
          return v;
        end
      end
    end
    return v;
  endfunction

  // advance the predicted line by one accepted byte
  function automatic line_effect_t take_byte(input logic [7:0] b, output verdict_t v);
    v = '0;
    if (b == CH_CR || b == CH_LF) begin
      // line end on an empty line is a no-op
      if (line_len == 0) return LINE_IGNORED;
      v = judge_line();
      line_len = 0;
      return LINE_VERDICT;
    end
    if (b == CH_BS || b == CH_DEL) begin
      if (line_len == 0) return LINE_IGNORED;
      line_len--;
      return LINE_UPDATED;
    end
    if (line_len < STORE_DEPTH) begin
      line_bytes[line_len] = b;
      line_len++;
      return LINE_UPDATED;
    end
    // store already full: byte dropped, line thrown away, too-long verdict
    line_len = 0;
    v.status = STATUS_TOO_LONG;
    v.code   = CODE_BLANK;
    return LINE_VERDICT;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic log_mismatch(input string why, input verdict_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("mismatch (%s): expected status %0d code %0d, got status %0d code %0d",
               why, want.status, want.code, out_status, out_command_code);
  endtask

  // every delivered verdict is paired with the oldest outstanding prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        log_mismatch("no request outstanding", '0);
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (out_status !== oldest_verdict.status ||
            out_command_code !== oldest_verdict.code)
          log_mismatch("wrong verdict", oldest_verdict);
      end
    end
  end

  // hang detector: counts cycles with no request moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall generator
  // ---------------------------------------------------------------------------

  // a long hold-off takes priority over the normal style; one assignment per edge
  always @(negedge clk) begin
    stall_next = 1'b0;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      case (rx_style)
        RX_RANDOM: begin
          stall_next = ($urandom_range(0, 99) < 35);
        end
        RX_PATTERN: begin
          stall_next  = stall_pattern[pattern_pos];
          pattern_pos = (pattern_pos + 1) % PATTERN_LEN;
          // now and then a fresh pattern; bit 0 kept low so it always opens
          if (pattern_pos == 0 && $urandom_range(0, 3) == 0) begin
            stall_pattern    = PATTERN_LEN'($urandom);
            stall_pattern[0] = 1'b0;
          end
        end
        default: begin
          stall_next = 1'b0;
        end
      endcase
    end
    out_stall <= stall_next;
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offer one byte, wait for it to be taken, then predict; gaps follow bursts
  task automatic send_byte(input logic [7:0] b);
    verdict_t     v;
    line_effect_t effect;
    int           gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    effect = take_byte(b, v);
    if (effect == LINE_VERDICT) pending_verdicts.push_back(v);
    // bytes the parser simply ignores do not count towards the total
    if (effect != LINE_IGNORED) items_counted++;
    if (tx_gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        case ($urandom_range(0, 19))
          0:       gap = $urandom_range(21, 60);
          1, 2, 3: gap = $urandom_range(4, 20);
          default: gap = $urandom_range(1, 3);
        endcase
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // sender goes quiet so the last byte is not offered again while waiting
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // one command line: a keyword (or a damaged one) with random case, blanks,
  // corrected typos, an occasional zero byte and a CR, LF or CR LF ending
  task automatic send_command_line(input int which, input bit mangle);
    logic [7:0] word [$];
    logic [7:0] c;
    string      kw;
    int         k;
    int         pos;
    k  = (which < 0) ? $urandom_range(0, KW_N - 1) : which;
    kw = kw_text[k];
    for (int i = 0; i < kw.len(); i++) word.push_back(kw[i]);
    if (mangle) begin
      pos = $urandom_range(0, word.size() - 1);
      case ($urandom_range(0, 3))
        0:       void'(word.pop_back());
        1:       word.push_back("A" + 8'($urandom_range(0, 25)));
        2:       word[pos] = "A" + 8'($urandom_range(0, 25));
        default: word.push_front("A" + 8'($urandom_range(0, 25)));
      endcase
    end
    repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    foreach (word[i]) begin
      // typo rubbed out again with backspace or delete
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(33, 126)));
        send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
      end
      c = word[i];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + CASE_DIFF;
      send_byte(c);
      if ($urandom_range(0, 9) == 0) send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    end
    // zero byte hides whatever follows it
    if ($urandom_range(0, 9) == 0) begin
      send_byte(CH_NUL);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(14, 255)));
    end
    case ($urandom_range(0, 2))
      0: send_byte(CH_CR);
      1: send_byte(CH_LF);
      default: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
    endcase
  endtask

  // raw bytes over the whole range; long runs overflow the store
  task automatic send_noise();
    repeat ($urandom_range(0, 40)) send_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) send_byte(CH_LF);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // edits and the corner cases of a short line
  task automatic test_line_edits();
    tx_gaps_on = 1'b0;
    rx_style   = RX_FREE;
    // line end, backspace and delete on an empty line are all ignored
    send_byte(CH_CR);
    send_byte(CH_BS);
    send_byte(CH_DEL);
    // lower case folded, stray byte deleted
    send_text("auX");
    send_byte(CH_DEL);
    send_text("to");
    send_byte(CH_CR);
    // only blanks: empty text, unknown
    send_byte(CH_SP);
    send_byte(CH_TAB);
    send_byte(CH_LF);
    // zero byte ends the text before the top byte value and the rest
    send_text("id");
    send_byte(CH_NUL);
    send_byte(8'hFF);
    send_text("le");
    send_byte(CH_LF);
    // high bytes stored and compared as they are
    send_byte(8'h80);
    send_byte(CH_CR);
    // alias, then a CR LF pair whose LF finds the line empty
    send_text("sleepY");
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // exactly full line that still matches, then a byte arriving on a full store
  task automatic test_full_store();
    tx_gaps_on = 1'b1;
    rx_style   = RX_RANDOM;
    for (int i = 0; i < STORE_DEPTH - 5; i++) send_byte(i[0] ? CH_SP : CH_TAB);
    send_text("alert");
    send_byte(CH_LF);
    for (int i = 0; i < STORE_DEPTH - 5; i++) send_byte(i[0] ? CH_TAB : CH_SP);
    send_text("HaPpY");
    send_byte(8'hFF);
    // the overflow already cleared the line
    send_byte(CH_LF);
  endtask

  task automatic test_every_keyword();
    rx_style = RX_PATTERN;
    for (int k = 0; k < KW_N; k++) send_command_line(k, 1'b0);
  endtask

  // receiver holds off long enough for the output and then the input to back up
  task automatic test_held_receiver();
    tx_gaps_on = 1'b0;
    rx_style   = RX_FREE;
    hold_requests++;
    repeat (12) send_command_line(-1, 1'b0);
    wait_results_drained();
  endtask

  // sender waits for every verdict before the next line
  task automatic test_drain_pause();
    tx_gaps_on = 1'b1;
    rx_style   = RX_RANDOM;
    repeat (6) begin
      send_command_line(-1, 1'b0);
      wait_results_drained();
    end
  endtask

  // bulk traffic: mostly well-formed commands, some damaged ones, some noise;
  // phases vary the idling on both sides, including stretches with none
  task automatic test_random_traffic();
    int phase_end;
    int pick;
    while (items_counted < ITEM_TARGET) begin
      rx_style   = rx_style_t'($urandom_range(0, 2));
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      phase_end  = items_counted + $urandom_range(60, 200);
      while (items_counted < phase_end && items_counted < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) send_command_line(-1, 1'b0);
        else if (pick < 85) send_command_line(-1, 1'b1);
        else send_noise();
        if ($urandom_range(0, 49) == 0) wait_results_drained();
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_line_edits();
    test_full_store();
    test_every_keyword();
    test_held_receiver();
    test_drain_pause();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    wait_results_drained();
    // let any late or spurious verdict show up
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/skcp_pkg.sv
rtl/skcp_ram.sv
rtl/skcp_match.sv
rtl/serial_keyword_command_parser.sv
tb/sv/tb_serial_keyword_command_parser.sv
